// ===== rtl/core/mwlfo_pkg.sv =====
`timescale 1ns / 1ps
package mwlfo_pkg;

  // value format: signed, FRAC_BITS fraction bits
  localparam int FRAC_BITS  = 20;
  localparam int VAL_BITS   = FRAC_BITS + 4;
  localparam int MAX_BLOCK  = 24;
  localparam int LEN_W      = 5;
  localparam int STEP_W     = 21;
  localparam int SEED_W     = 32;
  localparam int WAVE_W     = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // noise generator: 32 steps per draw, 8 steps per cycle
  localparam int RAND_CYCLES = 4;
  // restoring divider: one quotient bit per cycle
  localparam int DIV_BITS    = VAL_BITS + 1;
  localparam int CNT_W       = 5;

  localparam logic [SEED_W-1:0] LFSR_TAPS = 32'h8020_0003;

  localparam logic signed [VAL_BITS-1:0] ONE  = VAL_BITS'(1 << FRAC_BITS);
  localparam logic signed [VAL_BITS-1:0] VMAX = VAL_BITS'((1 << (VAL_BITS - 1)) - 1);
  localparam logic signed [VAL_BITS-1:0] VMIN = VAL_BITS'(1 << (VAL_BITS - 1));

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WAVEFORM = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED     = 2'd2;

  // waveform codes
  localparam logic [WAVE_W-1:0] WAVE_SINE     = 3'd0;
  localparam logic [WAVE_W-1:0] WAVE_TRIANGLE = 3'd1;
  localparam logic [WAVE_W-1:0] WAVE_SAW_UP   = 3'd2;
  localparam logic [WAVE_W-1:0] WAVE_SAW_DOWN = 3'd3;
  localparam logic [WAVE_W-1:0] WAVE_RECT     = 3'd4;
  localparam logic [WAVE_W-1:0] WAVE_HOLD     = 3'd5;

  typedef logic signed [VAL_BITS-1:0] val_t;

  typedef struct packed {
    logic             reset_level;
    logic [LEN_W-1:0] block_len;
  } in_t;

  typedef struct packed {
    logic signed [VAL_BITS-1:0] sample;
    logic                       last;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic trig;
    logic quad;
    logic rand_step;
    logic rand_done;
    logic mul;
    logic upd;
    logic div_start;
    logic div_step;
    logic emit;
    logic fin;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_empty;
    logic draw_pending;
    logic out_free;
    logic last_sample;
  } sts_t;

endpackage

// ===== rtl/core/mwlfo_ctrl.sv =====
`timescale 1ns / 1ps
module mwlfo_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  mwlfo_pkg::sts_t   sts_i,
  output mwlfo_pkg::cmd_t   cmd_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_TRIG = 4'd1;
  localparam logic [3:0] S_QUAD = 4'd2;
  localparam logic [3:0] S_RAND = 4'd3;
  localparam logic [3:0] S_MUL  = 4'd4;
  localparam logic [3:0] S_UPD  = 4'd5;
  localparam logic [3:0] S_DSET = 4'd6;
  localparam logic [3:0] S_DIV  = 4'd7;
  localparam logic [3:0] S_EMIT = 4'd8;
  localparam logic [3:0] S_FIN  = 4'd9;

  logic [3:0] state_q, state_d;
  logic [mwlfo_pkg::CNT_W-1:0] cnt_q, cnt_d;

  // sequencer
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (!sts_i.in_empty) state_d = S_TRIG;
        end
      end
      S_TRIG: begin
        cmd_o.trig = 1'b1;
        state_d    = S_QUAD;
      end
      S_QUAD: begin
        cmd_o.quad = 1'b1;
        cnt_d      = '0;
        state_d    = sts_i.draw_pending ? S_RAND : S_MUL;
      end
      S_RAND: begin
        cmd_o.rand_step = 1'b1;
        cnt_d           = cnt_q + 1'b1;
        if (cnt_q == mwlfo_pkg::CNT_W'(mwlfo_pkg::RAND_CYCLES - 1)) begin
          cmd_o.rand_done = 1'b1;
          state_d         = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_UPD;
      end
      S_UPD: begin
        cmd_o.upd = 1'b1;
        state_d   = S_DSET;
      end
      S_DSET: begin
        cmd_o.div_start = 1'b1;
        cnt_d           = '0;
        state_d         = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == mwlfo_pkg::CNT_W'(mwlfo_pkg::DIV_BITS - 1)) state_d = S_EMIT;
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.last_sample) state_d = S_FIN;
        end
      end
      S_FIN: begin
        cmd_o.fin = 1'b1;
        state_d   = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // a sample is only loaded into a free output slot
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> sts_i.out_free)
    else $error("sample loaded into occupied output slot");

  // the block closes only right after its last sample
  a_fin_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.fin |-> $past(cmd_o.emit && sts_i.last_sample))
    else $error("block closed without last sample");

  // no sample goes out right after the divide starts
  a_div_before_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |=> !cmd_o.emit)
    else $error("sample emitted before divide finished");

endmodule

// ===== rtl/core/mwlfo_dp.sv =====
`timescale 1ns / 1ps
module mwlfo_dp (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [mwlfo_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [mwlfo_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  mwlfo_pkg::in_t                        in_data_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output mwlfo_pkg::out_t                       out_data_o,
  input  mwlfo_pkg::cmd_t                       cmd_i,
  output mwlfo_pkg::sts_t                       sts_o
);

  localparam int VB = mwlfo_pkg::VAL_BITS;
  localparam int DB = mwlfo_pkg::DIV_BITS;
  localparam int PW = 2 * VB + 2;
  localparam int NC = 5;
  localparam logic [2:0] IDX_SINE  = 3'd0;
  localparam logic [2:0] IDX_SAW   = 3'd1;
  localparam logic [2:0] IDX_HOLD  = 3'd2;
  localparam logic [2:0] IDX_PHASE = 3'd3;
  localparam logic [2:0] IDX_RECT  = 3'd4;

  localparam logic [mwlfo_pkg::CFG_IDX_W-1:0] CFG_WAVE_SEL = mwlfo_pkg::CFG_WAVEFORM;
  localparam logic [mwlfo_pkg::CFG_IDX_W-1:0] CFG_STEP_SEL = mwlfo_pkg::CFG_STEP;
  localparam logic [mwlfo_pkg::CFG_IDX_W-1:0] CFG_SEED_SEL = mwlfo_pkg::CFG_SEED;

  function automatic mwlfo_pkg::val_t sat32(input logic signed [31:0] v);
    if (v > 32'(mwlfo_pkg::VMAX)) return mwlfo_pkg::VMAX;
    if (v < 32'(mwlfo_pkg::VMIN)) return mwlfo_pkg::VMIN;
    return VB'(v);
  endfunction

  function automatic logic [mwlfo_pkg::SEED_W-1:0] lfsr_adv8(
    input logic [mwlfo_pkg::SEED_W-1:0] s);
    logic [mwlfo_pkg::SEED_W-1:0] r;
    r = s;
    for (int n = 0; n < 8; n++) begin
      if (r[0]) r = (r >> 1) ^ mwlfo_pkg::LFSR_TAPS;
      else r = r >> 1;
    end
    return r;
  endfunction

  // configuration registers
  logic [mwlfo_pkg::WAVE_W-1:0] wave_q;
  logic [mwlfo_pkg::STEP_W-1:0] step_q;

  // oscillator state
  mwlfo_pkg::val_t phase_q, delta_q, saw_q, rect_q, hold_q, sine_q;
  logic [1:0]      quarter_q;
  logic            trig_seen_q;
  logic [mwlfo_pkg::SEED_W-1:0] lfsr_q;
  mwlfo_pkg::val_t cur_q [NC];

  // block working registers
  logic                        level_q;
  logic [mwlfo_pkg::LEN_W-1:0] k_q, i_q;
  logic signed [PW-1:0]        prod_q;
  mwlfo_pkg::val_t             csel_q;
  logic                        neg_q;
  logic [DB-1:0]               num_q, acc_q;
  logic [5:0]                  rem_q, racc_q;

  logic     out_valid_q;
  mwlfo_pkg::out_t out_q;

  mwlfo_pkg::val_t step_s, tgt [NC];
  logic [mwlfo_pkg::LEN_W-1:0] k_in;
  logic draw_cond;
  logic [mwlfo_pkg::SEED_W-1:0] lfsr_nx;
  logic signed [VB-1:0] pa;
  logic signed [VB+1:0] pb;
  logic signed [PW-1:0] prod_d;
  logic [PW-1:0] pmag;
  logic [PW-1:0] pround;
  logic signed [31:0] rnd_s, saw_sum, ph_sum;
  logic [2:0] sel;
  logic signed [VB:0] diff;
  logic [5:0] dt;
  logic [5:0] rs;
  logic [DB-1:0] qn;
  logic [5:0] rn;
  logic signed [31:0] v, vo;

  assign step_s = VB'({3'b000, step_q});
  assign k_in   = (in_data_i.block_len > mwlfo_pkg::LEN_W'(mwlfo_pkg::MAX_BLOCK)) ?
                  mwlfo_pkg::LEN_W'(mwlfo_pkg::MAX_BLOCK) : in_data_i.block_len;

  assign tgt[IDX_SINE]  = sine_q;
  assign tgt[IDX_SAW]   = saw_q;
  assign tgt[IDX_HOLD]  = hold_q;
  assign tgt[IDX_PHASE] = phase_q;
  assign tgt[IDX_RECT]  = rect_q;

  // half-period crossing that calls for a new random value
  assign draw_cond = !(phase_q >= mwlfo_pkg::ONE) && !(phase_q <= -mwlfo_pkg::ONE) &&
                     ((quarter_q == 2'd1 && phase_q < 0) ||
                      (quarter_q == 2'd3 && phase_q > 0));

  assign lfsr_nx = lfsr_adv8(lfsr_q);

  // parabolic sine product, 24 by 26 bits
  assign pa = phase_q;
  assign pb = (quarter_q < 2'd2) ? ((VB + 2)'(2 * mwlfo_pkg::ONE) - (VB + 2)'(pa))
                                 : ((VB + 2)'(2 * mwlfo_pkg::ONE) + (VB + 2)'(pa));
  assign prod_d = pa * pb;

  // round to nearest by ONE, ties away from zero
  assign pmag   = prod_q[PW-1] ? PW'(-prod_q) : PW'(prod_q);
  assign pround = (pmag + PW'(1 << (mwlfo_pkg::FRAC_BITS - 1))) >> mwlfo_pkg::FRAC_BITS;
  assign rnd_s  = prod_q[PW-1] ? -$signed(pround[31:0]) : $signed(pround[31:0]);
  assign saw_sum = 32'(saw_q) + 32'({12'd0, step_q[mwlfo_pkg::STEP_W-1:1]});
  assign ph_sum  = 32'(phase_q) + 32'(delta_q);

  // component that the selected waveform follows
  always_comb begin
    case (wave_q)
      mwlfo_pkg::WAVE_SINE:     sel = IDX_SINE;
      mwlfo_pkg::WAVE_TRIANGLE: sel = IDX_PHASE;
      mwlfo_pkg::WAVE_SAW_UP:   sel = IDX_SAW;
      mwlfo_pkg::WAVE_SAW_DOWN: sel = IDX_SAW;
      mwlfo_pkg::WAVE_RECT:     sel = IDX_RECT;
      mwlfo_pkg::WAVE_HOLD:     sel = IDX_HOLD;
      default:                  sel = IDX_SINE;
    endcase
  end

  assign diff = (VB + 1)'(tgt[sel]) - (VB + 1)'(cur_q[sel]);
  assign dt   = {rem_q[4:0], num_q[DB-1]};

  // incremental quotient and remainder of |d|*i + k/2 by k
  always_comb begin
    rs = racc_q + rem_q;
    qn = acc_q + num_q;
    rn = rs;
    if (rs >= 6'(k_q)) begin
      rn = rs - 6'(k_q);
      qn = qn + 1'b1;
    end
  end

  // interpolated value and waveform shaping
  always_comb begin
    v = neg_q ? (32'(csel_q) - 32'(qn)) : (32'(csel_q) + 32'(qn));
    case (wave_q)
      mwlfo_pkg::WAVE_SAW_DOWN,
      mwlfo_pkg::WAVE_RECT: vo = -v;
      mwlfo_pkg::WAVE_SINE,
      mwlfo_pkg::WAVE_TRIANGLE,
      mwlfo_pkg::WAVE_SAW_UP,
      mwlfo_pkg::WAVE_HOLD: vo = v;
      default: vo = '0;
    endcase
  end

  assign sts_o.in_empty     = (in_data_i.block_len == '0);
  assign sts_o.draw_pending = draw_cond;
  assign sts_o.out_free     = !out_valid_q || !out_stall_i;
  assign sts_o.last_sample  = (i_q == k_q);

  // configuration, trigger, quarter, noise, waveform and previous-target state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_q      <= mwlfo_pkg::WAVE_SINE;
      step_q      <= mwlfo_pkg::STEP_W'(4096);
      lfsr_q      <= mwlfo_pkg::SEED_W'(1);
      phase_q     <= '0;
      delta_q     <= mwlfo_pkg::val_t'(4096);
      quarter_q   <= 2'd0;
      trig_seen_q <= 1'b0;
      saw_q       <= -mwlfo_pkg::ONE;
      rect_q      <= '0;
      hold_q      <= '0;
      sine_q      <= '0;
      for (int j = 0; j < NC; j++) cur_q[j] <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_WAVE_SEL: wave_q <= cfg_data_i[mwlfo_pkg::WAVE_W-1:0];
          CFG_STEP_SEL: step_q <= cfg_data_i[mwlfo_pkg::STEP_W-1:0];
          CFG_SEED_SEL: lfsr_q <= (cfg_data_i == '0) ? mwlfo_pkg::SEED_W'(1)
                                                       : cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.trig) begin
        trig_seen_q <= level_q;
        if (!trig_seen_q && level_q) begin
          phase_q   <= '0;
          quarter_q <= 2'd0;
          delta_q   <= step_s;
          rect_q    <= -mwlfo_pkg::ONE;
          sine_q    <= '0;
        end
      end
      if (cmd_i.quad) begin
        if (phase_q >= mwlfo_pkg::ONE) begin
          quarter_q <= 2'd1;
          delta_q   <= -step_s;
        end else if (phase_q <= -mwlfo_pkg::ONE) begin
          quarter_q <= 2'd3;
          delta_q   <= step_s;
        end else if (quarter_q == 2'd1 && phase_q < 0) begin
          quarter_q <= 2'd2;
          rect_q    <= mwlfo_pkg::ONE;
        end else if (quarter_q == 2'd3 && phase_q > 0) begin
          quarter_q <= 2'd0;
          rect_q    <= -mwlfo_pkg::ONE;
          saw_q     <= -mwlfo_pkg::ONE;
        end
      end
      if (cmd_i.rand_step) lfsr_q <= lfsr_nx;
      if (cmd_i.rand_done) begin
        hold_q <= VB'({3'b000, lfsr_nx[mwlfo_pkg::SEED_W-1 -: mwlfo_pkg::FRAC_BITS + 1]})
                  - mwlfo_pkg::ONE;
      end
      if (cmd_i.upd) begin
        sine_q  <= sat32(rnd_s);
        saw_q   <= sat32(saw_sum);
        phase_q <= sat32(ph_sum);
      end
      if (cmd_i.fin) begin
        for (int j = 0; j < NC; j++) cur_q[j] <= tgt[j];
      end
    end
  end

  // block working registers: block inputs, product, divider, sample counter, output data
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      level_q <= in_data_i.reset_level;
      k_q     <= k_in;
    end
    if (cmd_i.mul) prod_q <= prod_d;
    if (cmd_i.div_start) begin
      csel_q <= cur_q[sel];
      neg_q  <= diff[VB];
      num_q  <= diff[VB] ? DB'(-diff) : DB'(diff);
      rem_q  <= '0;
    end
    if (cmd_i.div_step) begin
      if (dt >= 6'(k_q)) begin
        rem_q <= dt - 6'(k_q);
        num_q <= {num_q[DB-2:0], 1'b1};
      end else begin
        rem_q <= dt;
        num_q <= {num_q[DB-2:0], 1'b0};
      end
      acc_q  <= '0;
      racc_q <= 6'(k_q >> 1);
      i_q    <= mwlfo_pkg::LEN_W'(1);
    end
    if (cmd_i.emit) begin
      acc_q  <= qn;
      racc_q <= rn;
      i_q    <= i_q + 1'b1;
      out_q.sample <= sat32(vo);
      out_q.last   <= (i_q == k_q);
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/core/multiwave_lfo_block_interp.sv =====
`timescale 1ns / 1ps
// Block-rate low-frequency oscillator with six waveforms (parabolic sine, triangle,
// rising saw, falling saw, rectangle, sample-and-hold) in signed Q3.20. Each input
// transaction is one control block; it yields block_len (at most 24) output transactions
// that step linearly from the previous target to the new one, the last flagged by last.
// The sequencer steps through trigger, quarter, the noise generator (eight LFSR steps a
// cycle, only when a half-period crossing draws a new random value), multiply, update,
// divide setup and the restoring divider by k, then emits each sample when the output
// register is free, and closes the block. A new block is taken once the previous one
// has closed, while its last sample may still wait in the output register.
module multiwave_lfo_block_interp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [mwlfo_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [mwlfo_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  mwlfo_pkg::in_t                    in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output mwlfo_pkg::out_t                   out_data_o
);

  mwlfo_pkg::cmd_t cmd;
  mwlfo_pkg::sts_t sts;

  // block sequencer
  mwlfo_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // oscillator, divider and output register
  mwlfo_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

// ===== verif/tb_multiwave_lfo_block_interp.sv =====
`timescale 1ns / 1ps
module tb_multiwave_lfo_block_interp;

  localparam longint UNIT = longint'(1) << mwlfo_pkg::FRAC_BITS;
  localparam longint SAT_HI = (longint'(1) << (mwlfo_pkg::VAL_BITS - 1)) - 1;
  localparam longint SAT_LO = -SAT_HI - 1;
  localparam logic [mwlfo_pkg::WAVE_W-1:0] WAVE_SPARE_A = 3'd6;
  localparam logic [mwlfo_pkg::WAVE_W-1:0] WAVE_SPARE_B = 3'd7;
  localparam int SETTLE_CYCLES = 64;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int CYCLE_LIMIT = 1000000;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [mwlfo_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [mwlfo_pkg::CFG_DATA_W-1:0] cfg_data_i;
  logic in_valid_i;
  logic in_stall_o;
  mwlfo_pkg::in_t in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  mwlfo_pkg::out_t out_data_o;

  multiwave_lfo_block_interp i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o)
  );

  // oscillator state mirrored by the predictor
  logic [mwlfo_pkg::WAVE_W-1:0] wave_sel;
  longint step_reg;
  longint lfo_phase, lfo_delta, saw_lvl, rect_lvl, hold_lvl, sine_lvl;
  longint interp_prev [5];
  int unsigned lfo_quarter;
  bit trig_prev;
  logic [mwlfo_pkg::SEED_W-1:0] noise_reg;

  mwlfo_pkg::out_t sample_queue[$];
  int errors = 0;
  bit no_idle_rx = 0;
  bit hold_off_req = 0;

  // clock
  always begin
    clk_i = 1'b1; #4;
    clk_i = 1'b0; #4;
  end

  // cycle limit
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("FAIL");
    $finish;
  end

  function automatic longint clip(longint v);
    if (v > SAT_HI) return SAT_HI;
    if (v < SAT_LO) return SAT_LO;
    return v;
  endfunction

  // round to nearest, ties away from zero
  function automatic longint rdiv(longint num, longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = (mag + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic longint noise_draw();
    for (int i = 0; i < 32; i++) begin
      if (noise_reg[0]) noise_reg = (noise_reg >> 1) ^ mwlfo_pkg::LFSR_TAPS;
      else noise_reg = noise_reg >> 1;
    end
    return longint'(noise_reg >> (31 - mwlfo_pkg::FRAC_BITS)) - UNIT;
  endfunction

  task automatic lfo_reset_state();
    wave_sel = mwlfo_pkg::WAVE_SINE;
    step_reg = 4096;
    lfo_phase = 0;
    lfo_delta = step_reg;
    lfo_quarter = 0;
    trig_prev = 0;
    saw_lvl = -UNIT;
    rect_lvl = 0;
    hold_lvl = 0;
    sine_lvl = 0;
    foreach (interp_prev[j]) interp_prev[j] = 0;
    noise_reg = 1;
  endtask

  // advance one control block and queue its samples; returns the final sample
  function automatic mwlfo_pkg::val_t lfo_block(mwlfo_pkg::in_t blk);
    longint k;
    longint tgt [5];
    longint v [5];
    longint s;
    mwlfo_pkg::out_t o;
    k = blk.block_len;
    o = '0;
    if (k == 0) return '0;
    if (k > mwlfo_pkg::MAX_BLOCK) k = mwlfo_pkg::MAX_BLOCK;
    if (!trig_prev && blk.reset_level) begin
      lfo_phase = 0;
      lfo_quarter = 0;
      lfo_delta = step_reg;
      rect_lvl = -UNIT;
      sine_lvl = 0;
    end
    trig_prev = blk.reset_level;
    if (lfo_phase >= UNIT) begin
      lfo_quarter = 1;
      lfo_delta = -step_reg;
    end else if (lfo_phase <= -UNIT) begin
      lfo_quarter = 3;
      lfo_delta = step_reg;
    end else if (lfo_quarter == 1 && lfo_phase < 0) begin
      lfo_quarter = 2;
      rect_lvl = UNIT;
      hold_lvl = noise_draw();
    end else if (lfo_quarter == 3 && lfo_phase > 0) begin
      lfo_quarter = 0;
      rect_lvl = -UNIT;
      hold_lvl = noise_draw();
      saw_lvl = -UNIT;
    end
    if (lfo_quarter < 2) sine_lvl = clip(rdiv(lfo_phase * (2 * UNIT - lfo_phase), UNIT));
    else sine_lvl = clip(rdiv(lfo_phase * (2 * UNIT + lfo_phase), UNIT));
    saw_lvl = clip(saw_lvl + step_reg / 2);
    lfo_phase = clip(lfo_phase + lfo_delta);
    tgt[0] = sine_lvl;
    tgt[1] = saw_lvl;
    tgt[2] = hold_lvl;
    tgt[3] = lfo_phase;
    tgt[4] = rect_lvl;
    for (longint i = 1; i <= k; i++) begin
      for (int j = 0; j < 5; j++)
        v[j] = interp_prev[j] + rdiv((tgt[j] - interp_prev[j]) * i, k);
      case (wave_sel)
        mwlfo_pkg::WAVE_SINE:     s = v[0];
        mwlfo_pkg::WAVE_TRIANGLE: s = v[3];
        mwlfo_pkg::WAVE_SAW_UP:   s = v[1];
        mwlfo_pkg::WAVE_SAW_DOWN: s = clip(-v[1]);
        mwlfo_pkg::WAVE_RECT:     s = clip(-v[4]);
        mwlfo_pkg::WAVE_HOLD:     s = v[2];
        default:                  s = 0;
      endcase
      o.sample = mwlfo_pkg::val_t'(s);
      o.last = (i == k);
      sample_queue.push_back(o);
    end
    for (int j = 0; j < 5; j++) interp_prev[j] = tgt[j];
    return o.sample;
  endfunction

  // register write, only while idle
  task automatic write_reg(logic [mwlfo_pkg::CFG_IDX_W-1:0] idx,
                           logic [mwlfo_pkg::CFG_DATA_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      mwlfo_pkg::CFG_WAVEFORM: wave_sel = data[mwlfo_pkg::WAVE_W-1:0];
      mwlfo_pkg::CFG_STEP:     step_reg = data[mwlfo_pkg::STEP_W-1:0];
      mwlfo_pkg::CFG_SEED:     noise_reg = (data == 0) ? 1 : data;
      default: ;
    endcase
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sample_queue.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // offer one block, wait for the transaction, then predict it
  task automatic send_block(mwlfo_pkg::in_t blk, int gap, output mwlfo_pkg::val_t fin);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= blk;
    do @(posedge clk_i); while (in_stall_o);
    fin = lfo_block(blk);
  endtask

  // output side: check each transaction, then draw the next stall
  initial begin
    int hold;
    mwlfo_pkg::out_t want;
    hold = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (sample_queue.size() == 0) begin
          errors++;
          $display("%0t unexpected sample: expected none, actual %h/%b", $time,
                   out_data_o.sample, out_data_o.last);
        end else begin
          want = sample_queue.pop_front();
          if (out_data_o.sample !== want.sample) begin
            errors++;
            $display("%0t sample: expected %h, actual %h", $time, want.sample,
                     out_data_o.sample);
          end
          if (out_data_o.last !== want.last) begin
            errors++;
            $display("%0t last: expected %b, actual %b", $time, want.last,
                     out_data_o.last);
          end
        end
        hold = no_idle_rx ? 0 : $urandom_range(0, 8);
      end
      if (hold_off_req) begin
        hold = HOLD_OFF_CYCLES;
        hold_off_req = 0;
      end
      out_stall_i <= (hold > 0);
      if (hold > 0) hold--;
    end
  end

  typedef struct {
    bit lvl;
    logic [mwlfo_pkg::LEN_W-1:0] len;
    bit typed;
    mwlfo_pkg::val_t want_fin;
  } dir_row_t;

  typedef struct {
    logic [mwlfo_pkg::WAVE_W-1:0] wave;
    logic [mwlfo_pkg::CFG_DATA_W-1:0] step;
    logic [mwlfo_pkg::CFG_DATA_W-1:0] seed;
    bit no_idle;
    bit pressure;
  } phase_row_t;

  // stimulus
  initial begin
    dir_row_t dir_rows [$];
    phase_row_t phases [$];
    mwlfo_pkg::in_t blk;
    mwlfo_pkg::val_t fin;
    bit lvl;
    int r;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    lfo_reset_state();
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed blocks at reset settings: first sine target is zero
    dir_rows = '{
      '{0, 5'd1, 1, '0}, '{0, 5'd0, 0, '0}, '{0, 5'd24, 0, '0}, '{1, 5'd8, 0, '0},
      '{1, 5'd3, 0, '0}, '{0, 5'd5, 0, '0}, '{1, 5'd25, 0, '0}, '{0, 5'd31, 0, '0},
      '{1, 5'd1, 0, '0}, '{1, 5'd0, 0, '0}, '{0, 5'd16, 0, '0}, '{0, 5'd2, 0, '0},
      '{1, 5'd24, 0, '0}, '{0, 5'd7, 0, '0}, '{1, 5'd31, 0, '0}, '{0, 5'd1, 0, '0}
    };
    foreach (dir_rows[i]) begin
      blk.reset_level = dir_rows[i].lvl;
      blk.block_len = dir_rows[i].len;
      send_block(blk, $urandom_range(0, 8), fin);
      if (dir_rows[i].typed && fin !== dir_rows[i].want_fin) begin
        errors++;
        $display("%0t directed row %0d: expected %h, actual %h", $time, i,
                 dir_rows[i].want_fin, fin);
      end
    end
    drain();

    // register settings, extremes among them
    phases = '{
      '{mwlfo_pkg::WAVE_SINE, 262144, 0, 0, 0},
      '{mwlfo_pkg::WAVE_TRIANGLE, 1048576, 32'hffff_ffff, 0, 0},
      '{mwlfo_pkg::WAVE_SAW_UP, 1, 1, 0, 0},
      '{mwlfo_pkg::WAVE_SAW_DOWN, 2097151, $urandom, 0, 0},
      '{mwlfo_pkg::WAVE_RECT, 65536, $urandom, 1, 0},
      '{mwlfo_pkg::WAVE_HOLD, 131072, $urandom, 0, 1},
      '{WAVE_SPARE_A, 0, 7, 0, 0},
      '{WAVE_SPARE_B, 300000, $urandom, 0, 0},
      '{mwlfo_pkg::WAVE_HOLD, 2097151, 0, 0, 0},
      '{mwlfo_pkg::WAVE_TRIANGLE, $urandom_range(1, 1048576), $urandom, 0, 0},
      '{mwlfo_pkg::WAVE_SINE, $urandom_range(1, 1048576), $urandom, 1, 0}
    };
    lvl = 0;
    foreach (phases[p]) begin
      write_reg(mwlfo_pkg::CFG_WAVEFORM, phases[p].wave);
      write_reg(mwlfo_pkg::CFG_STEP, phases[p].step);
      write_reg(mwlfo_pkg::CFG_SEED, phases[p].seed);
      no_idle_rx = phases[p].no_idle;
      if (phases[p].pressure) hold_off_req = 1;
      for (int n = 0; n < 36; n++) begin
        if ($urandom_range(0, 3) == 0) lvl = ~lvl;
        r = $urandom_range(0, 19);
        blk.reset_level = lvl;
        if (r == 0) blk.block_len = 0;
        else if (r == 1) blk.block_len = $urandom_range(mwlfo_pkg::MAX_BLOCK + 1, 31);
        else blk.block_len = $urandom_range(1, mwlfo_pkg::MAX_BLOCK);
        send_block(blk, (phases[p].no_idle || phases[p].pressure) ? 0
                   : $urandom_range(0, 8), fin);
      end
      drain();
    end

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
